// ----- hdl/kmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared constants, key tables and lane result type for the key matrix
// scan decoder.
// ----------------------------------------------------------------------------
package kmsd_pkg;

    // default matrix size
    localparam int ROWS_DEF = 7;
    localparam int COLS_DEF = 5;

    // key bits at or above this index never count as pressed
    localparam int KEY_LIMIT = 64;

    // row/col index width (up to 16 rows or columns)
    localparam int IDX_W = 4;

    localparam int CODE_W = 7;

    // modifier key positions
    localparam int ALT_ROW    = 4;
    localparam int ALT_COL    = 0;
    localparam int RSHIFT_ROW = 3;
    localparam int RSHIFT_COL = 2;
    localparam int LSHIFT_ROW = 6;
    localparam int LSHIFT_COL = 1;

    localparam int TBL_ROWS = 7;
    localparam int TBL_COLS = 5;

    localparam logic [CODE_W-1:0] CASE_OFFSET = 7'd32;
    localparam logic [CODE_W-1:0] UPPER_A     = 7'h41;
    localparam logic [CODE_W-1:0] UPPER_Z     = 7'h5A;

    // primary characters, [row][col]
    localparam logic [CODE_W-1:0] PRIM_TBL [TBL_ROWS][TBL_COLS] = '{
        '{7'h51, 7'h45, 7'h52, 7'h55, 7'h4F},  // Q E R U O
        '{7'h57, 7'h53, 7'h47, 7'h48, 7'h4C},  // W S G H L
        '{7'h00, 7'h44, 7'h54, 7'h59, 7'h49},  // - D T Y I
        '{7'h41, 7'h50, 7'h00, 7'h0A, 7'h0D},  // A P - LF CR
        '{7'h00, 7'h58, 7'h56, 7'h42, 7'h24},  // - X V B $
        '{7'h20, 7'h5A, 7'h43, 7'h4E, 7'h4D},  // sp Z C N M
        '{7'h00, 7'h00, 7'h46, 7'h4A, 7'h4B}   // - - F J K
    };

    // alternate characters, [row][col]; zero means none
    localparam logic [CODE_W-1:0] ALT_TBL [TBL_ROWS][TBL_COLS] = '{
        '{7'h23, 7'h32, 7'h33, 7'h5F, 7'h2B},  // # 2 3 _ +
        '{7'h31, 7'h34, 7'h2F, 7'h3A, 7'h22},  // 1 4 / : "
        '{7'h00, 7'h35, 7'h28, 7'h29, 7'h2D},  // - 5 ( ) -
        '{7'h2A, 7'h40, 7'h00, 7'h00, 7'h00},  // * @
        '{7'h00, 7'h38, 7'h3F, 7'h21, 7'h00},  // - 8 ? !
        '{7'h00, 7'h37, 7'h39, 7'h2C, 7'h2E},  // - 7 9 , .
        '{7'h30, 7'h00, 7'h36, 7'h3B, 7'h27}   // 0 - 6 ; '
    };

    // what one column lane found: last pressed key and its characters
    typedef struct packed {
        logic              hit;
        logic              multi;
        logic [CODE_W-1:0] prim;
        logic [CODE_W-1:0] alt;
    } lane_hit_t;

    function automatic logic [CODE_W-1:0] prim_at(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        logic [CODE_W-1:0] ch;
        ch = '0;
        if ((int'(r) < TBL_ROWS) && (int'(c) < TBL_COLS))
        begin
            ch = PRIM_TBL[r[2:0]][c[2:0]];
        end
        return ch;
    endfunction

    function automatic logic [CODE_W-1:0] alt_at(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        logic [CODE_W-1:0] ch;
        ch = '0;
        if ((int'(r) < TBL_ROWS) && (int'(c) < TBL_COLS))
        begin
            ch = ALT_TBL[r[2:0]][c[2:0]];
        end
        return ch;
    endfunction

endpackage

// ----- hdl/kmsd_lane.sv -----
// ----------------------------------------------------------------------------
// kmsd_lane
// One column of the matrix: finds the last pressed row, flags more than one
// pressed key and looks up that key's characters.
// ----------------------------------------------------------------------------
module kmsd_lane
    import kmsd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COL  = 0
)
(
    input  logic [ROWS-1:0] col_keys,
    output lane_hit_t       found
);

    always_comb
    begin
        found = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (col_keys[r])
            begin
                found.multi = found.multi | found.hit;
                found.hit   = 1'b1;
                found.prim  = prim_at(IDX_W'(r), IDX_W'(COL));
                found.alt   = alt_at(IDX_W'(r), IDX_W'(COL));
            end
        end
    end

endmodule

// ----- hdl/kmsd_merge.sv -----
// ----------------------------------------------------------------------------
// kmsd_merge
// Combines the column lanes: picks the last pressed key in column-major
// order; applies the pending modifier to a lone key, else lowercases letters.
// ----------------------------------------------------------------------------
module kmsd_merge
    import kmsd_pkg::*;
#(
    parameter int COLS = COLS_DEF
)
(
    input  lane_hit_t         lanes [COLS],
    input  logic              alt_flag,
    input  logic              shift_flag,
    output logic [CODE_W-1:0] key_code
);

    lane_hit_t sel;
    logic      any_hit;
    logic      many;

    always_comb
    begin
        sel     = '0;
        any_hit = 1'b0;
        many    = 1'b0;
        for (int c = 0; c < COLS; c++)
        begin
            if (lanes[c].hit)
            begin
                many    = many | any_hit | lanes[c].multi;
                any_hit = 1'b1;
                sel     = lanes[c];
            end
        end
    end

    // modifier only reaches the last key when it is also the first
    always_comb
    begin
        if (!many && alt_flag)
        begin
            key_code = (sel.alt != '0) ? sel.alt : sel.prim;
        end
        else if (!many && shift_flag)
        begin
            key_code = sel.prim;
        end
        else if ((sel.prim >= UPPER_A) && (sel.prim <= UPPER_Z))
        begin
            key_code = sel.prim + CASE_OFFSET;
        end
        else
        begin
            key_code = sel.prim;
        end
    end

endmodule

// ----- hdl/key_matrix_scan_decoder.sv -----
// ----------------------------------------------------------------------------
// key_matrix_scan_decoder
// Keyboard matrix scanner: compares snapshots, tracks sticky modifiers and
// decodes the pressed key to ASCII.
// ----------------------------------------------------------------------------
// Takes one full matrix snapshot per beat on the scan channel and returns
// one registered result beat per snapshot on the code channel. A new
// snapshot is taken every clock cycle as long as the code channel drains;
// the only storage in the data path is the output register, so the block
// stalls only when a result is held and code_stall is high. Snapshot bit
// row*COLS+col is one key; bits at index 64 and above never count. Alt
// (row 4 col 0) and either shift key (row 3 col 2, row 6 col 1) do not
// report a change; they set a sticky flag that the next reported key uses
// when it is pressed alone. With several keys down the code comes from the
// last key in column-major order, with letters lowercased.
// ----------------------------------------------------------------------------
module key_matrix_scan_decoder
    import kmsd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // snapshot channel
    input  logic                 scan_valid,
    output logic                 scan_stall,
    input  logic [ROWS*COLS-1:0] pressed_matrix,

    // result channel
    output logic                 code_valid,
    input  logic                 code_stall,
    output logic                 changed,
    output logic [CODE_W-1:0]    key_code,
    output logic                 alt_pending,
    output logic                 shift_pending
);

    localparam int NKEYS = ROWS * COLS;

    logic [NKEYS-1:0]  keys;
    logic [ROWS-1:0]   col_keys [COLS];
    lane_hit_t         lanes [COLS];
    logic [CODE_W-1:0] dec_code;

    logic alt_key;
    logic rshift_key;
    logic lshift_key;
    logic change_now;
    logic take;

    logic [NKEYS-1:0]  matrix_prev_reg;
    logic              alt_flag_reg;
    logic              alt_flag_next;
    logic              shift_flag_reg;
    logic              shift_flag_next;
    logic              out_valid_reg;
    logic              changed_reg;
    logic [CODE_W-1:0] key_code_reg;
    logic              alt_out_reg;
    logic              shift_out_reg;

    // ---- key bits, dropping positions the scanner never sees ----
    for (genvar i = 0; i < NKEYS; i++)
    begin : g_key
        if (i < KEY_LIMIT)
        begin : g_live
            assign keys[i] = pressed_matrix[i];
        end
        else
        begin : g_dead
            assign keys[i] = 1'b0;
        end
    end

    // ---- modifier taps; a position outside the matrix never acts ----
    if ((ALT_ROW < ROWS) && (ALT_COL < COLS))
    begin : g_alt
        assign alt_key = keys[ALT_ROW*COLS + ALT_COL];
    end
    else
    begin : g_no_alt
        assign alt_key = 1'b0;
    end

    if ((RSHIFT_ROW < ROWS) && (RSHIFT_COL < COLS))
    begin : g_rshift
        assign rshift_key = keys[RSHIFT_ROW*COLS + RSHIFT_COL];
    end
    else
    begin : g_no_rshift
        assign rshift_key = 1'b0;
    end

    if ((LSHIFT_ROW < ROWS) && (LSHIFT_COL < COLS))
    begin : g_lshift
        assign lshift_key = keys[LSHIFT_ROW*COLS + LSHIFT_COL];
    end
    else
    begin : g_no_lshift
        assign lshift_key = 1'b0;
    end

    // ---- one lane per column, all working on the same snapshot ----
    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        for (genvar r = 0; r < ROWS; r++)
        begin : g_row
            assign col_keys[c][r] = keys[r*COLS + c];
        end

        kmsd_lane #(
            .ROWS (ROWS),
            .COL  (c)
        ) u_lane (
            .col_keys (col_keys[c]),
            .found    (lanes[c])
        );
    end

    kmsd_merge #(
        .COLS (COLS)
    ) u_merge (
        .lanes      (lanes),
        .alt_flag   (alt_flag_reg),
        .shift_flag (shift_flag_reg),
        .key_code   (dec_code)
    );

    // ---- change detect and sticky flags ----
    assign change_now = (keys != matrix_prev_reg) && (|keys)
                        && !alt_key && !rshift_key && !lshift_key;

    always_comb
    begin
        alt_flag_next   = alt_flag_reg;
        shift_flag_next = shift_flag_reg;
        if (alt_key)
        begin
            alt_flag_next = 1'b1;
        end
        else if (rshift_key || lshift_key)
        begin
            shift_flag_next = 1'b1;
        end
        else if (change_now)
        begin
            // the first decoded key consumes both flags
            alt_flag_next   = 1'b0;
            shift_flag_next = 1'b0;
        end
    end

    // ---- handshake: the output register frees itself when taken ----
    assign scan_stall = out_valid_reg && code_stall;
    assign take       = scan_valid && !scan_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_prev_reg <= '0;
            alt_flag_reg    <= 1'b0;
            shift_flag_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                matrix_prev_reg <= keys;
                alt_flag_reg    <= alt_flag_next;
                shift_flag_reg  <= shift_flag_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!code_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            changed_reg   <= change_now;
            key_code_reg  <= change_now ? dec_code : '0;
            alt_out_reg   <= alt_flag_next;
            shift_out_reg <= shift_flag_next;
        end
    end

    assign code_valid    = out_valid_reg;
    assign changed       = changed_reg;
    assign key_code      = key_code_reg;
    assign alt_pending   = alt_out_reg;
    assign shift_pending = shift_out_reg;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key matrix scan decoder.
// ----------------------------------------------------------------------------
// A queue of matrix snapshots is built at time zero: a short directed list
// that walks the modifier, fallback and unused-key cases, then typing-like
// random sequences mixed with chords and raw noise. A clocked driver sends
// the snapshots in bursts with random gaps. Each accepted beat goes through
// a local decoder that keeps its own previous snapshot and sticky flags, and
// the expected result is queued. A clocked monitor, with a receiver that
// stalls on its own shifting pattern, checks every result beat against the
// oldest expectation.
// ----------------------------------------------------------------------------
module testbench
    import kmsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MATRIX_W   = ROWS_DEF * COLS_DEF;
    localparam int ITEM_COUNT = 650;
    localparam int ALT_BIT    = ALT_ROW * COLS_DEF + ALT_COL;
    localparam int RSHIFT_BIT = RSHIFT_ROW * COLS_DEF + RSHIFT_COL;
    localparam int LSHIFT_BIT = LSHIFT_ROW * COLS_DEF + LSHIFT_COL;
    localparam int MAX_REPORTS = 10;

    typedef logic [MATRIX_W-1:0] matrix_t;

    // one snapshot to send; drain_first holds it back until all codes are in
    typedef struct {
        matrix_t bits;
        bit      drain_first;
    } scan_job_t;

    typedef struct packed {
        logic              changed;
        logic [CODE_W-1:0] code;
        logic              alt;
        logic              shift;
    } key_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              scan_valid     = 1'b0;
    logic              scan_stall;
    matrix_t           pressed_matrix = '0;
    logic              code_valid;
    logic              code_stall     = 1'b0;
    logic              changed;
    logic [CODE_W-1:0] key_code;
    logic              alt_pending;
    logic              shift_pending;

    always #10 clk = ~clk;

    key_matrix_scan_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan_valid     (scan_valid),
        .scan_stall     (scan_stall),
        .pressed_matrix (pressed_matrix),
        .code_valid     (code_valid),
        .code_stall     (code_stall),
        .changed        (changed),
        .key_code       (key_code),
        .alt_pending    (alt_pending),
        .shift_pending  (shift_pending)
    );

    // ------------------------------------------------------------------------
    // local decoder state: previous snapshot and the two sticky modifiers
    // ------------------------------------------------------------------------
    matrix_t     last_snapshot = '0;
    logic        alt_sticky    = 1'b0;
    logic        shift_sticky  = 1'b0;

    scan_job_t   scan_jobs[$];
    key_result_t codes_due[$];
    int          job_total   = 0;
    int          beats_taken = 0;
    int          error_count = 0;

    // Decode one accepted snapshot and queue the code it must produce.
    task automatic decode_snapshot(input matrix_t m);
        logic              report;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] prim;
        logic [CODE_W-1:0] alt;
        report = (m != last_snapshot) && (m != '0);
        code   = '0;
        last_snapshot = m;

        // a held modifier suppresses the report; alt wins over both shifts
        if (m[ALT_BIT])
        begin
            report     = 1'b0;
            alt_sticky = 1'b1;
        end
        else if (m[RSHIFT_BIT] || m[LSHIFT_BIT])
        begin
            report       = 1'b0;
            shift_sticky = 1'b1;
        end

        // column-major walk; first key eats the modifier, last key wins
        if (report)
        begin
            for (int c = 0; c < COLS_DEF; c++)
            begin
                for (int r = 0; r < ROWS_DEF; r++)
                begin
                    if (m[r * COLS_DEF + c])
                    begin
                        prim = PRIM_TBL[r][c];
                        alt  = ALT_TBL[r][c];
                        if (alt_sticky)
                        begin
                            code         = (alt != '0) ? alt : prim;
                            alt_sticky   = 1'b0;
                            shift_sticky = 1'b0;
                        end
                        else if (shift_sticky)
                        begin
                            // shifted keys keep the primary (uppercase) char
                            code         = prim;
                            alt_sticky   = 1'b0;
                            shift_sticky = 1'b0;
                        end
                        else if (prim >= UPPER_A && prim <= UPPER_Z)
                        begin
                            code = prim + CASE_OFFSET;
                        end
                        else
                        begin
                            code = prim;
                        end
                    end
                end
            end
        end

        codes_due.push_back('{report, report ? code : '0, alt_sticky, shift_sticky});
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic matrix_t key_at(int r, int c);
        matrix_t m;
        m = '0;
        m[r * COLS_DEF + c] = 1'b1;
        return m;
    endfunction

    // any key that is not a modifier
    function automatic matrix_t plain_key();
        int unsigned idx;
        matrix_t     m;
        m = '0;
        do
            idx = $urandom_range(0, MATRIX_W - 1);
        while (idx == ALT_BIT || idx == RSHIFT_BIT || idx == LSHIFT_BIT);
        m[idx] = 1'b1;
        return m;
    endfunction

    function automatic matrix_t modifier_key();
        matrix_t m;
        m = '0;
        case ($urandom_range(0, 2))
            0:       m[ALT_BIT]    = 1'b1;
            1:       m[RSHIFT_BIT] = 1'b1;
            default: m[LSHIFT_BIT] = 1'b1;
        endcase
        return m;
    endfunction

    task automatic add_scan(input matrix_t m);
        scan_jobs.push_back('{m, 1'b0});
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of beats with random gaps; payload frozen while stalled
    // ------------------------------------------------------------------------
    int        burst_left = 1;
    int        idle_left  = 0;
    logic      next_valid;
    logic      took_beat;
    scan_job_t next_job;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_beat = scan_valid && !scan_stall;
            if (took_beat)
            begin
                decode_snapshot(pressed_matrix);
                beats_taken++;
            end
            if (took_beat || !scan_valid)
            begin
                next_valid = 1'b0;
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (scan_jobs.size() > 0 &&
                         !(scan_jobs[0].drain_first && codes_due.size() > 0))
                begin
                    next_job       = scan_jobs.pop_front();
                    pressed_matrix <= next_job.bits;
                    next_valid     = 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // a quarter of the bursts run straight into the next
                        burst_left = $urandom_range(1, 24);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                scan_valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: an 8-bit rotating pattern, redrawn when its age counter
    // runs out; bit 0 is always cleared so the pattern never stalls forever
    // ------------------------------------------------------------------------
    logic [7:0] stall_shape = '0;
    int         stall_age   = 0;

    always @(posedge clk)
    begin
        if (stall_age == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_shape = '0;
                1:       stall_shape = 8'($urandom);
                2:       stall_shape = 8'($urandom) | 8'($urandom);
                default: stall_shape = 8'($urandom) & 8'($urandom);
            endcase
            stall_shape[0] = 1'b0;
            stall_age      = $urandom_range(16, 80);
        end
        else
        begin
            stall_age--;
        end
        code_stall  <= stall_shape[0];
        stall_shape = {stall_shape[0], stall_shape[7:1]};
    end

    // ------------------------------------------------------------------------
    // monitor: each result beat against the oldest expectation
    // ------------------------------------------------------------------------
    key_result_t want;
    key_result_t got;

    always @(posedge clk)
    begin
        if (rst_n && code_valid && !code_stall)
        begin
            got = '{changed, key_code, alt_pending, shift_pending};
            if (codes_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display({"%0t: result beat with nothing expected: ",
                              "changed=%b code=%h alt=%b shift=%b"},
                             $realtime, got.changed, got.code, got.alt, got.shift);
            end
            else
            begin
                want = codes_due.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: changed %b/%b code %h/%h ",
                                  "alt %b/%b shift %b/%b (exp/act)"},
                                 $realtime, want.changed, got.changed,
                                 want.code, got.code,
                                 want.alt, got.alt, want.shift, got.shift);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        matrix_t prev_pick;

        // directed: flags, fallbacks, unused keys, chords, extremes
        add_scan('0);                                   // nothing down, no report
        add_scan(key_at(0, 0));                         // plain letter, lowercased
        add_scan(key_at(0, 0));                         // same snapshot, no report
        add_scan({MATRIX_W{1'b1}});                     // every key: alt wins
        add_scan('0);
        add_scan(key_at(0, 1));                         // alt char
        add_scan(key_at(RSHIFT_ROW, RSHIFT_COL));       // right shift
        add_scan('0);
        add_scan(key_at(LSHIFT_ROW, LSHIFT_COL));       // left shift
        add_scan(key_at(3, 0));                         // shifted stays uppercase
        add_scan(key_at(ALT_ROW, ALT_COL) | key_at(RSHIFT_ROW, RSHIFT_COL));
        add_scan(key_at(3, 3));                         // alt with no alt char
        add_scan(key_at(2, 0));                         // unused position, code 0
        add_scan(key_at(ALT_ROW, ALT_COL));
        add_scan(key_at(0, 0) | key_at(6, 4));          // first eats alt, last wins
        add_scan(key_at(RSHIFT_ROW, RSHIFT_COL) | key_at(LSHIFT_ROW, LSHIFT_COL));
        add_scan(key_at(4, 4));                         // shifted non-letter
        add_scan(key_at(ALT_ROW, ALT_COL));
        add_scan(key_at(4, 4));                         // alt fallback to primary
        add_scan(key_at(5, 0));                         // space
        add_scan(key_at(6, 4));                         // top bit alone
        add_scan(matrix_t'(35'h5_5555_5555));
        add_scan(matrix_t'(35'h2_AAAA_AAAA));
        add_scan(key_at(3, 4));

        // random: mostly typing sequences, then chords and raw noise
        prev_pick = '0;
        while (scan_jobs.size() < ITEM_COUNT)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_scan(modifier_key());
                    prev_pick = plain_key();
                    add_scan(prev_pick);
                    if ($urandom_range(0, 1) == 1)
                        add_scan('0);
                end
                3:
                    add_scan(prev_pick);
                4, 5:
                begin
                    prev_pick = plain_key() | plain_key();
                    if ($urandom_range(0, 1) == 1)
                        prev_pick |= plain_key() | plain_key();
                    add_scan(prev_pick);
                end
                6:
                    add_scan(modifier_key() | modifier_key() |
                             (($urandom_range(0, 1) == 1) ? plain_key() : '0));
                7:
                begin
                    add_scan(modifier_key());
                    add_scan(plain_key() | plain_key() | plain_key());
                end
                default:
                    add_scan(matrix_t'({$urandom, $urandom}));
            endcase
            // now and then hold the sender until the result side is empty
            if (scan_jobs.size() == 25 || $urandom_range(0, 99) == 0)
                scan_jobs[scan_jobs.size() - 1].drain_first = 1'b1;
        end
        job_total = scan_jobs.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken < job_total)
            @(posedge clk);
        while (codes_due.size() != 0)
            @(posedge clk);
        // a short tail catches stray beats
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- key_matrix_scan_decoder.f -----
hdl/kmsd_pkg.sv
hdl/kmsd_lane.sv
hdl/kmsd_merge.sv
hdl/key_matrix_scan_decoder.sv
verif/testbench.sv
